[src/efr_pkg.sv]
// Shared types and constants for the escaped frame receiver.
// No dependencies; every other file refers to this package by scoped names.
`default_nettype none

package efr_pkg;

    localparam int BUF_DEPTH = 256;
    localparam int LIMIT_CAP = (BUF_DEPTH < 511) ? BUF_DEPTH : 511;
    localparam logic [8:0] LIMIT_CAP_W = 9'(LIMIT_CAP);
    localparam logic [8:0] HDR_BYTES = 9'd2;

    localparam logic [1:0] REG_BEGIN_CODE   = 2'd0;
    localparam logic [1:0] REG_END_CODE     = 2'd1;
    localparam logic [1:0] REG_ESCAPE_CODE  = 2'd2;
    localparam logic [1:0] REG_BUFFER_LIMIT = 2'd3;

    localparam logic [7:0] BEGIN_CODE_RST   = 8'd2;
    localparam logic [7:0] END_CODE_RST     = 8'd3;
    localparam logic [7:0] ESCAPE_CODE_RST  = 8'd27;
    localparam logic [8:0] BUFFER_LIMIT_RST = 9'd256;

    localparam logic [1:0] EV_NONE    = 2'd0;
    localparam logic [1:0] EV_STORED  = 2'd1;
    localparam logic [1:0] EV_FRAME   = 2'd2;
    localparam logic [1:0] EV_DROPPED = 2'd3;

    typedef enum logic [2:0] {
        KIND_CLEAR,
        KIND_ESCAPE,
        KIND_BEGIN,
        KIND_END,
        KIND_DATA
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
    } item_t;

    typedef struct packed {
        logic [7:0] begin_code;
        logic [7:0] end_code;
        logic [7:0] escape_code;
    } codes_t;

    typedef struct packed {
        logic [1:0] event_res;
        logic [7:0] byte_value;
        logic [7:0] byte_index;
        logic [7:0] frame_cmd;
        logic [7:0] frame_arg;
        logic [7:0] payload_count;
        logic       short_frame;
        logic       packet_ready;
        logic       overflow_flag;
    } result_t;

endpackage

`default_nettype wire

[src/efr_front.sv]
// Front end: tracks the escape state and classifies each received beat.
// Depends on efr_pkg.
`default_nettype none

module efr_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire efr_pkg::codes_t codes,
    input  wire logic           in_valid,
    input  wire logic           in_opcode,
    input  wire logic [7:0]     in_data,
    input  wire logic           in_ready,
    output efr_pkg::item_t      item
);

    logic escape_pending_reg;
    logic escape_pending_next;

    always_comb
    begin
        escape_pending_next = escape_pending_reg;
        item.data = in_data;
        if (in_opcode)
        begin
            item.kind = efr_pkg::KIND_CLEAR;
        end
        else if (in_data == codes.escape_code && !escape_pending_reg)
        begin
            item.kind = efr_pkg::KIND_ESCAPE;
            escape_pending_next = 1'b1;
        end
        else if (in_data == codes.begin_code && !escape_pending_reg)
        begin
            item.kind = efr_pkg::KIND_BEGIN;
        end
        else if (in_data == codes.end_code && !escape_pending_reg)
        begin
            item.kind = efr_pkg::KIND_END;
        end
        else
        begin
            item.kind = efr_pkg::KIND_DATA;
            escape_pending_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            escape_pending_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            escape_pending_reg <= escape_pending_next;
        end
    end

endmodule

`default_nettype wire

[src/efr_queue.sv]
// Two-entry queue of classified beats between front and back end.
// Depends on efr_pkg.
`default_nettype none

module efr_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire efr_pkg::item_t push_item,
    output logic                full,
    input  wire logic           pop,
    output logic                not_empty,
    output efr_pkg::item_t      head
);

    efr_pkg::item_t entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head      = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

[src/efr_back.sv]
// Back end: frame counters, header capture, flags and the result register.
// Depends on efr_pkg.
`default_nettype none

module efr_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic [8:0]     buffer_limit,
    input  wire logic           item_valid,
    input  wire efr_pkg::item_t item,
    output logic                item_pop,
    output logic                out_valid,
    input  wire logic           out_ready,
    output efr_pkg::result_t    result
);

    logic       out_valid_reg;
    logic [8:0] stored_count_reg;
    logic [8:0] stored_count_next;
    logic       overflow_reg;
    logic       overflow_next;
    logic       ready_flag_reg;
    logic       ready_flag_next;
    logic [7:0] command_reg;
    logic [7:0] command_next;
    logic [7:0] argument_reg;
    logic [7:0] argument_next;
    logic [8:0] limit;
    logic [8:0] payload_wide;
    efr_pkg::result_t result_reg;
    efr_pkg::result_t result_next;

    assign item_pop  = item_valid && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign result    = result_reg;
    assign limit     = (buffer_limit > efr_pkg::LIMIT_CAP_W) ? efr_pkg::LIMIT_CAP_W
                                                             : buffer_limit;
    assign payload_wide = stored_count_reg - efr_pkg::HDR_BYTES;

    always_comb
    begin
        stored_count_next = stored_count_reg;
        overflow_next     = overflow_reg;
        ready_flag_next   = ready_flag_reg;
        command_next      = command_reg;
        argument_next     = argument_reg;
        result_next       = '0;
        case (item.kind)
            efr_pkg::KIND_CLEAR:
            begin
                ready_flag_next = 1'b0;
            end
            efr_pkg::KIND_ESCAPE:
            begin
            end
            efr_pkg::KIND_BEGIN:
            begin
                stored_count_next = '0;
                ready_flag_next   = 1'b0;
            end
            efr_pkg::KIND_END:
            begin
                result_next.event_res = efr_pkg::EV_FRAME;
                result_next.frame_cmd = command_reg;
                result_next.frame_arg = argument_reg;
                if (stored_count_reg < efr_pkg::HDR_BYTES)
                begin
                    result_next.short_frame = 1'b1;
                end
                else if (payload_wide[8])
                begin
                    result_next.payload_count = 8'hFF;
                end
                else
                begin
                    result_next.payload_count = payload_wide[7:0];
                end
                ready_flag_next = 1'b1;
            end
            efr_pkg::KIND_DATA:
            begin
                if (stored_count_reg < limit)
                begin
                    result_next.event_res  = efr_pkg::EV_STORED;
                    result_next.byte_value = item.data;
                    result_next.byte_index = stored_count_reg[7:0];
                    if (stored_count_reg == 9'd0)
                    begin
                        command_next = item.data;
                    end
                    else if (stored_count_reg == 9'd1)
                    begin
                        argument_next = item.data;
                    end
                    stored_count_next = stored_count_reg + 9'd1;
                end
                else
                begin
                    result_next.event_res = efr_pkg::EV_DROPPED;
                    overflow_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        result_next.packet_ready  = ready_flag_next;
        result_next.overflow_flag = overflow_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg    <= 1'b0;
            stored_count_reg <= '0;
            overflow_reg     <= 1'b0;
            ready_flag_reg   <= 1'b0;
            command_reg      <= '0;
            argument_reg     <= '0;
        end
        else
        begin
            if (item_pop)
            begin
                out_valid_reg    <= 1'b1;
                stored_count_reg <= stored_count_next;
                overflow_reg     <= overflow_next;
                ready_flag_reg   <= ready_flag_next;
                command_reg      <= command_next;
                argument_reg     <= argument_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_pop)
        begin
            result_reg <= result_next;
        end
    end

endmodule

`default_nettype wire

[src/escaped_frame_receiver.sv]
// Escaped frame receiver: removes byte stuffing and reports stored bytes and frames.
// A beat accepted into the queue entry register is popped by the back end into the result register.
// Throughput: one beat per cycle while m_tready does not stall the result register.
// A two-entry queue decouples the classifying front end from the back end.
// Reset: rst_n clears flags, counters and queue; codes return to 2, 3, 27, limit 256.
// Depends on efr_pkg, efr_front, efr_queue and efr_back.
`default_nettype none

module escaped_frame_receiver (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic        s_tuser,   // [0] opcode
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [7:0] byte_value, [15:8] byte_index, [23:16] frame_cmd, [31:24] frame_arg,
    // [39:32] payload_count, [40] short_frame, [41] packet_ready,
    // [42] overflow_flag, [47:43] zero
    output logic [47:0]      m_tdata,
    output logic [1:0]       m_tuser,   // [1:0] event_res
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [8:0]  cfg_data
);

    efr_pkg::codes_t  codes_reg;
    logic [8:0]       buffer_limit_reg;
    efr_pkg::item_t   front_item;
    efr_pkg::item_t   queue_head;
    efr_pkg::result_t result;
    logic             queue_full;
    logic             queue_not_empty;
    logic             queue_pop;
    logic             in_accept;

    assign cfg_ready = 1'b1;
    assign s_tready  = !queue_full;
    assign in_accept = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            codes_reg.begin_code  <= efr_pkg::BEGIN_CODE_RST;
            codes_reg.end_code    <= efr_pkg::END_CODE_RST;
            codes_reg.escape_code <= efr_pkg::ESCAPE_CODE_RST;
            buffer_limit_reg      <= efr_pkg::BUFFER_LIMIT_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                efr_pkg::REG_BEGIN_CODE:   codes_reg.begin_code  <= cfg_data[7:0];
                efr_pkg::REG_END_CODE:     codes_reg.end_code    <= cfg_data[7:0];
                efr_pkg::REG_ESCAPE_CODE:  codes_reg.escape_code <= cfg_data[7:0];
                efr_pkg::REG_BUFFER_LIMIT: buffer_limit_reg      <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    efr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .codes     (codes_reg),
        .in_valid  (s_tvalid),
        .in_opcode (s_tuser),
        .in_data   (s_tdata),
        .in_ready  (s_tready),
        .item      (front_item)
    );

    efr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_accept),
        .push_item (front_item),
        .full      (queue_full),
        .pop       (queue_pop),
        .not_empty (queue_not_empty),
        .head      (queue_head)
    );

    efr_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .buffer_limit (buffer_limit_reg),
        .item_valid   (queue_not_empty),
        .item         (queue_head),
        .item_pop     (queue_pop),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .result       (result)
    );

    assign m_tuser = result.event_res;
    assign m_tdata = {5'd0, result.overflow_flag, result.packet_ready, result.short_frame,
                      result.payload_count, result.frame_arg, result.frame_cmd,
                      result.byte_index, result.byte_value};

endmodule

`default_nettype wire
